// ===== rtl/core/sxrp_pkg.sv =====
package sxrp_pkg;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  localparam logic [15:0] PORT_MISC_WR   = 16'h03C2;
  localparam logic [15:0] PORT_SEQ_IDX   = 16'h03C4;
  localparam logic [15:0] PORT_SEQ_DATA  = 16'h03C5;
  localparam logic [15:0] PORT_GFX_IDX   = 16'h03CE;
  localparam logic [15:0] PORT_GFX_DATA  = 16'h03CF;
  localparam logic [15:0] PORT_CRTC_IDX  = 16'h03D4;
  localparam logic [15:0] PORT_CRTC_DATA = 16'h03D5;
  localparam logic [15:0] PORT_ALT_WR    = 16'h03D8;
  localparam logic [15:0] PORT_ALT_RD    = 16'h03D9;

  localparam logic [11:0] PORT_MONO_BLK  = 12'h03B;
  localparam logic [11:0] PORT_COLOR_BLK = 12'h03D;
  localparam logic [15:0] PORT_SWAP_MASK = 16'h0060;

  localparam logic [3:0] SEQ_ID       = 4'hB;
  localparam logic [3:0] SEQ_POWER_UP = 4'hC;
  localparam logic [3:0] SEQ_CTRL_TWO = 4'hD;
  localparam logic [3:0] SEQ_BANK     = 4'hE;
  localparam logic [3:0] GFX_BANK     = 4'hE;
  localparam logic [3:0] GFX_BANK_CTL = 4'hF;

  localparam logic [7:0] SEQ_ID_VALUE = 8'h33;
  localparam logic [7:0] BANK_XOR     = 8'h02;

  localparam logic [5:0] CRTC_PROT_REG  = 6'h11;
  localparam logic [5:0] CRTC_PROT_LAST = 6'h07;
  localparam logic [5:0] CRTC_FIXED_LO  = 6'h0E;
  localparam logic [5:0] CRTC_FIXED_HI  = 6'h10;

  typedef struct packed {
    logic       fwd;
    logic [7:0] fwd_data;
    logic       valid;
  } crtc_rd_t;

endpackage

// ===== rtl/core/svga_extended_register_port.sv =====
// Channel | Valid       | Stall        | Payload
// in      | in_valid_i  | in_stall_o   | operation_i, port_address_i, write_data_i
// out     | out_valid_o | out_stall_i  | read_data_o, handled_o, read_bank_o, write_bank_o,
//         |             |              | row_double_o, timing_change_o
//
// One item per cycle sustained while the output is not stalled; an accepted item passes
// through the input register, then the result register, to the output.
// The CRTC store is a memory whose entry at the current index is prefetched into a
// register every cycle; per-entry valid bits make unwritten entries read as zero.
// Reset clears the state registers and all valid bits at once; no clearing pass is needed.
// A stalled output holds its item; the input register still takes one more item.
module svga_extended_register_port import sxrp_pkg::*; #(
  parameter int unsigned CRTC_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [15:0] port_address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        handled_o,
  output logic [4:0]  read_bank_o,
  output logic [4:0]  write_bank_o,
  output logic        row_double_o,
  output logic        timing_change_o
);

  localparam int unsigned AW = $clog2(CRTC_DEPTH);
  localparam logic [6:0] DEPTH_W = 7'(CRTC_DEPTH);

  logic        s1_valid_q;
  op_e         s1_op_q;
  logic [15:0] s1_addr_q;
  logic [7:0]  s1_data_q;
  logic        s1_adv;
  logic        in_take;

  logic        out_valid_q;
  logic [7:0]  read_data_q;
  logic        handled_q;
  logic        timing_q;

  logic        colour_select_q, colour_select_d;
  logic [3:0]  seq_index_q, seq_index_d;
  logic [3:0]  gfx_index_q, gfx_index_d;
  logic [5:0]  crtc_index_q, crtc_index_d;
  logic [7:0]  power_up_q, power_up_d;
  logic [7:0]  seq_bank_q, seq_bank_d;
  logic [7:0]  gfx_bank_q, gfx_bank_d;
  logic [7:0]  gfx_ctl_q, gfx_ctl_d;
  logic        old_mode_q, old_mode_d;
  logic [7:0]  old_ctl2_q, old_ctl2_d;
  logic [7:0]  new_ctl2_q, new_ctl2_d;
  logic [7:0]  alt_wr_q, alt_wr_d;
  logic [7:0]  alt_rd_q, alt_rd_d;
  logic [4:0]  rbank_q, rbank_d;
  logic [4:0]  wbank_q, wbank_d;
  logic        prot_q;

  logic [7:0]            crtc_mem [CRTC_DEPTH];
  logic [CRTC_DEPTH-1:0] crtc_vld_q;
  logic [7:0]            mem_rd_q;
  crtc_rd_t              crtc_rd_q;
  logic [7:0]            crtc_cur;
  logic                  crtc_we;
  logic                  idx_in_range;
  logic                  idxd_in_range;

  logic [15:0] addr;
  logic [7:0]  rd_val;
  logic        handled;
  logic        timing;
  logic [7:0]  seq_new;
  logic [7:0]  gfx_new;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  assign idx_in_range  = {1'b0, crtc_index_q} < DEPTH_W;
  assign idxd_in_range = {1'b0, crtc_index_d} < DEPTH_W;

  assign crtc_cur = crtc_rd_q.fwd ? crtc_rd_q.fwd_data :
                    (crtc_rd_q.valid ? mem_rd_q : 8'h00);

  always_comb begin
    addr = s1_addr_q;
    if (((s1_addr_q[15:4] == PORT_COLOR_BLK) || (s1_addr_q[15:4] == PORT_MONO_BLK)) &&
        !colour_select_q) begin
      addr = s1_addr_q ^ PORT_SWAP_MASK;
    end
  end

  always_comb begin
    colour_select_d = colour_select_q;
    seq_index_d     = seq_index_q;
    gfx_index_d     = gfx_index_q;
    crtc_index_d    = crtc_index_q;
    power_up_d      = power_up_q;
    seq_bank_d      = seq_bank_q;
    gfx_bank_d      = gfx_bank_q;
    gfx_ctl_d       = gfx_ctl_q;
    old_mode_d      = old_mode_q;
    old_ctl2_d      = old_ctl2_q;
    new_ctl2_d      = new_ctl2_q;
    alt_wr_d        = alt_wr_q;
    alt_rd_d        = alt_rd_q;
    rbank_d         = rbank_q;
    wbank_d         = wbank_q;
    rd_val          = 8'h00;
    handled         = 1'b0;
    timing          = 1'b0;
    crtc_we         = 1'b0;
    seq_new         = s1_data_q ^ BANK_XOR;
    gfx_new         = s1_data_q ^ BANK_XOR;
    if (s1_adv && (s1_op_q == OP_WRITE)) begin
      unique case (addr)
        PORT_MISC_WR: colour_select_d = s1_data_q[0];
        PORT_SEQ_IDX: seq_index_d = s1_data_q[3:0];
        PORT_GFX_IDX: gfx_index_d = s1_data_q[3:0];
        PORT_SEQ_DATA: begin
          unique case (seq_index_q)
            SEQ_ID: begin
              old_mode_d = 1'b1;
              handled    = 1'b1;
            end
            SEQ_POWER_UP: begin
              if (seq_bank_q[7]) power_up_d = s1_data_q;
              handled = 1'b1;
            end
            SEQ_CTRL_TWO: begin
              if (old_mode_q) old_ctl2_d = s1_data_q;
              else new_ctl2_d = s1_data_q;
              handled = 1'b1;
            end
            SEQ_BANK: begin
              seq_bank_d = seq_new;
              wbank_d    = {1'b0, seq_new[3:0]};
              if (!gfx_ctl_q[0]) rbank_d = {1'b0, seq_new[3:0]};
              handled = 1'b1;
            end
            default: ;
          endcase
        end
        PORT_GFX_DATA: begin
          if (gfx_index_q == GFX_BANK) begin
            gfx_bank_d = gfx_new;
            if (gfx_ctl_q[0]) rbank_d = {1'b0, gfx_new[3:0]};
            handled = 1'b1;
          end else if (gfx_index_q == GFX_BANK_CTL) begin
            gfx_ctl_d = s1_data_q;
            rbank_d   = s1_data_q[0] ? {1'b0, gfx_bank_q[3:0]} : {1'b0, seq_bank_q[3:0]};
            wbank_d   = {1'b0, seq_bank_q[3:0]};
            handled   = 1'b1;
          end
        end
        PORT_CRTC_IDX: begin
          crtc_index_d = s1_data_q[5:0];
          handled      = 1'b1;
        end
        PORT_CRTC_DATA: begin
          handled = 1'b1;
          if (!((crtc_index_q <= CRTC_PROT_LAST) && prot_q) && idx_in_range) begin
            crtc_we = 1'b1;
            if ((crtc_cur != s1_data_q) &&
                ((crtc_index_q < CRTC_FIXED_LO) || (crtc_index_q > CRTC_FIXED_HI))) begin
              timing = 1'b1;
            end
          end
        end
        PORT_ALT_WR: begin
          alt_wr_d = s1_data_q;
          handled  = 1'b1;
          if (gfx_ctl_q[2]) begin
            wbank_d = s1_data_q[4:0];
            if (!gfx_ctl_q[0]) rbank_d = s1_data_q[4:0];
          end
        end
        PORT_ALT_RD: begin
          alt_rd_d = s1_data_q;
          handled  = 1'b1;
          if (gfx_ctl_q[2] && gfx_ctl_q[0]) rbank_d = s1_data_q[4:0];
        end
        default: ;
      endcase
    end else if (s1_adv) begin
      unique case (addr)
        PORT_SEQ_DATA: begin
          unique case (seq_index_q)
            SEQ_ID: begin
              old_mode_d = 1'b0;
              handled    = 1'b1;
              rd_val     = SEQ_ID_VALUE;
            end
            SEQ_POWER_UP: begin
              handled = 1'b1;
              rd_val  = power_up_q;
            end
            SEQ_CTRL_TWO: begin
              handled = 1'b1;
              rd_val  = old_mode_q ? old_ctl2_q : new_ctl2_q;
            end
            SEQ_BANK: begin
              handled = 1'b1;
              rd_val  = seq_bank_q;
            end
            default: ;
          endcase
        end
        PORT_GFX_DATA: begin
          if (gfx_index_q == GFX_BANK) begin
            handled = 1'b1;
            rd_val  = gfx_bank_q;
          end else if (gfx_index_q == GFX_BANK_CTL) begin
            handled = 1'b1;
            rd_val  = gfx_ctl_q;
          end
        end
        PORT_CRTC_IDX: begin
          handled = 1'b1;
          rd_val  = {2'b00, crtc_index_q};
        end
        PORT_CRTC_DATA: begin
          handled = 1'b1;
          rd_val  = crtc_cur;
        end
        PORT_ALT_WR: begin
          handled = 1'b1;
          rd_val  = alt_wr_q;
        end
        PORT_ALT_RD: begin
          handled = 1'b1;
          rd_val  = alt_rd_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q   <= op_e'(operation_i);
      s1_addr_q <= port_address_i;
      s1_data_q <= write_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      read_data_q <= rd_val;
      handled_q   <= handled;
      timing_q    <= timing;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_select_q <= 1'b0;
      seq_index_q     <= '0;
      gfx_index_q     <= '0;
      crtc_index_q    <= '0;
      power_up_q      <= '0;
      seq_bank_q      <= '0;
      gfx_bank_q      <= '0;
      gfx_ctl_q       <= '0;
      old_mode_q      <= 1'b0;
      old_ctl2_q      <= '0;
      new_ctl2_q      <= '0;
      alt_wr_q        <= '0;
      alt_rd_q        <= '0;
      rbank_q         <= '0;
      wbank_q         <= '0;
      prot_q          <= 1'b0;
      crtc_vld_q      <= '0;
      crtc_rd_q       <= '0;
    end else begin
      colour_select_q <= colour_select_d;
      seq_index_q     <= seq_index_d;
      gfx_index_q     <= gfx_index_d;
      crtc_index_q    <= crtc_index_d;
      power_up_q      <= power_up_d;
      seq_bank_q      <= seq_bank_d;
      gfx_bank_q      <= gfx_bank_d;
      gfx_ctl_q       <= gfx_ctl_d;
      old_mode_q      <= old_mode_d;
      old_ctl2_q      <= old_ctl2_d;
      new_ctl2_q      <= new_ctl2_d;
      alt_wr_q        <= alt_wr_d;
      alt_rd_q        <= alt_rd_d;
      rbank_q         <= rbank_d;
      wbank_q         <= wbank_d;
      if (crtc_we && (crtc_index_q == CRTC_PROT_REG)) prot_q <= s1_data_q[7];
      if (crtc_we) crtc_vld_q[crtc_index_q[AW-1:0]] <= 1'b1;
      crtc_rd_q.fwd      <= crtc_we && (crtc_index_d == crtc_index_q);
      crtc_rd_q.fwd_data <= s1_data_q;
      crtc_rd_q.valid    <= idxd_in_range && crtc_vld_q[crtc_index_d[AW-1:0]];
    end
  end

  // write the current index, prefetch the next; crtc_rd_q forwards a same-cycle write
  always_ff @(posedge clk_i) begin
    if (crtc_we) crtc_mem[crtc_index_q[AW-1:0]] <= s1_data_q;
    mem_rd_q <= crtc_mem[crtc_index_d[AW-1:0]];
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = read_data_q;
  assign handled_o       = handled_q;
  assign timing_change_o = timing_q;
  assign read_bank_o     = rbank_q;
  assign write_bank_o    = wbank_q;
  assign row_double_o    = old_ctl2_q[4];

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked item");

  a_timing_handled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && timing_change_o) |-> handled_o)
    else $error("timing change on an item not served here");

  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !s1_adv) |=> !out_valid_q)
    else $error("output item repeated");

  a_crtc_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (crtc_we && (crtc_index_d == crtc_index_q)) |=> (crtc_cur == $past(s1_data_q)))
    else $error("CRTC prefetch missed a write");

  a_prot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crtc_we |-> idx_in_range)
    else $error("CRTC write beyond store depth");

endmodule

// ===== test/svga_extended_register_port_tb.sv =====
module svga_extended_register_port_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sxrp_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1950;
  localparam int unsigned HOLD_AT        = 600;
  localparam int unsigned DRAIN_AT       = 1300;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  localparam logic [15:0] DAC_FIRST      = 16'h03C6;
  localparam logic [15:0] DAC_LAST       = 16'h03C9;
  localparam logic [15:0] DAC_WR_INDEX   = 16'h03C8;
  localparam logic [15:0] PORT_BANK_PASS = 16'h03CD;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef struct packed {
    logic [7:0] read_data;
    logic       handled;
    logic [4:0] read_bank;
    logic [4:0] write_bank;
    logic       row_double;
    logic       timing_change;
  } port_result_t;

  class ext_reg_shadow;
    bit         colour_sel;
    bit [3:0]   seq_idx;
    bit [3:0]   gfx_idx;
    bit [5:0]   crtc_idx;
    bit [7:0]   crtc_regs [64];
    bit [7:0]   power_up;
    bit [7:0]   seq_bank;
    bit [7:0]   gfx_bank;
    bit [7:0]   gfx_bank_ctl;
    bit         old_mode;
    bit [7:0]   ctrl_two_old;
    bit [7:0]   ctrl_two_new;
    bit [7:0]   alt_wr;
    bit [7:0]   alt_rd;
    bit [4:0]   rd_bank;
    bit [4:0]   wr_bank;
    port_result_t expected_results [$];
    int unsigned  mismatches;

    function void note_access(op_e op, logic [15:0] port_in, logic [7:0] data);
      logic [15:0]  port;
      logic [7:0]   rd;
      logic         hit;
      logic         timing;
      port_result_t res;
      port   = port_in;
      rd     = '0;
      hit    = 1'b0;
      timing = 1'b0;
      if ((port[15:4] == PORT_MONO_BLK || port[15:4] == PORT_COLOR_BLK) && !colour_sel)
        port ^= PORT_SWAP_MASK;
      if (op == OP_WRITE) begin
        case (port)
          PORT_MISC_WR: colour_sel = data[0];
          PORT_SEQ_IDX: seq_idx = data[3:0];
          PORT_GFX_IDX: gfx_idx = data[3:0];
          PORT_SEQ_DATA: begin
            case (seq_idx)
              SEQ_ID: begin
                old_mode = 1'b1;
                hit = 1'b1;
              end
              SEQ_POWER_UP: begin
                if (seq_bank[7]) power_up = data;
                hit = 1'b1;
              end
              SEQ_CTRL_TWO: begin
                if (old_mode) ctrl_two_old = data;
                else ctrl_two_new = data;
                hit = 1'b1;
              end
              SEQ_BANK: begin
                seq_bank = data ^ BANK_XOR;
                wr_bank = {1'b0, seq_bank[3:0]};
                if (!gfx_bank_ctl[0]) rd_bank = wr_bank;
                hit = 1'b1;
              end
              default: ;
            endcase
          end
          PORT_GFX_DATA: begin
            if (gfx_idx == GFX_BANK) begin
              gfx_bank = data ^ BANK_XOR;
              if (gfx_bank_ctl[0]) rd_bank = {1'b0, gfx_bank[3:0]};
              hit = 1'b1;
            end else if (gfx_idx == GFX_BANK_CTL) begin
              gfx_bank_ctl = data;
              rd_bank = data[0] ? {1'b0, gfx_bank[3:0]} : {1'b0, seq_bank[3:0]};
              wr_bank = {1'b0, seq_bank[3:0]};
              hit = 1'b1;
            end
          end
          PORT_CRTC_IDX: begin
            crtc_idx = data[5:0];
            hit = 1'b1;
          end
          PORT_CRTC_DATA: begin
            hit = 1'b1;
            if (!(crtc_idx <= CRTC_PROT_LAST && crtc_regs[CRTC_PROT_REG][7])) begin
              if (crtc_regs[crtc_idx] != data &&
                  (crtc_idx < CRTC_FIXED_LO || crtc_idx > CRTC_FIXED_HI))
                timing = 1'b1;
              crtc_regs[crtc_idx] = data;
            end
          end
          PORT_ALT_WR: begin
            alt_wr = data;
            hit = 1'b1;
            if (gfx_bank_ctl[2]) begin
              wr_bank = data[4:0];
              if (!gfx_bank_ctl[0]) rd_bank = data[4:0];
            end
          end
          PORT_ALT_RD: begin
            alt_rd = data;
            hit = 1'b1;
            if (gfx_bank_ctl[0] && gfx_bank_ctl[2]) rd_bank = data[4:0];
          end
          default: ;
        endcase
      end else begin
        case (port)
          PORT_SEQ_DATA: begin
            case (seq_idx)
              SEQ_ID: begin
                old_mode = 1'b0;
                hit = 1'b1;
                rd = SEQ_ID_VALUE;
              end
              SEQ_POWER_UP: begin
                hit = 1'b1;
                rd = power_up;
              end
              SEQ_CTRL_TWO: begin
                hit = 1'b1;
                rd = old_mode ? ctrl_two_old : ctrl_two_new;
              end
              SEQ_BANK: begin
                hit = 1'b1;
                rd = seq_bank;
              end
              default: ;
            endcase
          end
          PORT_GFX_DATA: begin
            if (gfx_idx == GFX_BANK) begin
              hit = 1'b1;
              rd = gfx_bank;
            end else if (gfx_idx == GFX_BANK_CTL) begin
              hit = 1'b1;
              rd = gfx_bank_ctl;
            end
          end
          PORT_CRTC_IDX: begin
            hit = 1'b1;
            rd = {2'b00, crtc_idx};
          end
          PORT_CRTC_DATA: begin
            hit = 1'b1;
            rd = crtc_regs[crtc_idx];
          end
          PORT_ALT_WR: begin
            hit = 1'b1;
            rd = alt_wr;
          end
          PORT_ALT_RD: begin
            hit = 1'b1;
            rd = alt_rd;
          end
          default: ;
        endcase
      end
      res.read_data     = hit ? rd : 8'h00;
      res.handled       = hit;
      res.read_bank     = rd_bank;
      res.write_bank    = wr_bank;
      res.row_double    = ctrl_two_old[4];
      res.timing_change = timing;
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(port_result_t got);
      port_result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no access pending: read_data %h handled %b",
               got.read_data, got.handled);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("handled", 8'(want.handled), 8'(got.handled));
      compare_field("read_bank", 8'(want.read_bank), 8'(got.read_bank));
      compare_field("write_bank", 8'(want.write_bank), 8'(got.write_bank));
      compare_field("row_double", 8'(want.row_double), 8'(got.row_double));
      compare_field("timing_change", 8'(want.timing_change), 8'(got.timing_change));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic        operation = 1'b0;
  logic [15:0] port_address = '0;
  logic [7:0]  write_data = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data_o;
  logic        handled_o;
  logic [4:0]  read_bank_o;
  logic [4:0]  write_bank_o;
  logic        row_double_o;
  logic        timing_change_o;

  wire in_fire  = in_valid && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall;

  ext_reg_shadow shadow = new;
  int unsigned   items_sent = 0;
  int unsigned   burst_left = 0;
  bit            hold_req = 1'b0;

  svga_extended_register_port uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation),
    .port_address_i (port_address),
    .write_data_i   (write_data),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .read_data_o    (read_data_o),
    .handled_o      (handled_o),
    .read_bank_o    (read_bank_o),
    .write_bank_o   (write_bank_o),
    .row_double_o   (row_double_o),
    .timing_change_o(timing_change_o)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_fire) shadow.note_access(op_e'(operation), port_address, write_data);
      if (out_fire)
        shadow.check_result('{read_data_o, handled_o, read_bank_o, write_bank_o,
                              row_double_o, timing_change_o});
    end
  end

  initial begin : receiver
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned period;
    int unsigned phase;
    mode = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    period = 2;
    phase = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
        period = $urandom_range(2, 7);
      end
      mode_left--;
      phase++;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
          default:     out_stall <= (phase % period == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || in_fire || out_fire) quiet = 0;
      else quiet++;
    end
    $display("FAIL svga_extended_register_port");
    $finish;
  end

  task automatic pause_sender(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_item(op_e op, logic [15:0] port, logic [7:0] data);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
    end
    burst_left--;
    in_valid     <= 1'b1;
    operation    <= op;
    port_address <= port;
    write_data   <= data;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (shadow.expected_results.size() != 0);
  endtask

  function automatic op_e any_op();
    return op_e'($urandom_range(0, 1));
  endfunction

  function automatic logic [15:0] either_block(logic [15:0] port);
    return {(($urandom_range(0, 1) != 0) ? PORT_MONO_BLK : PORT_COLOR_BLK), port[3:0]};
  endfunction

  task automatic random_sequence();
    int unsigned kind;
    int unsigned count;
    logic [7:0]  idx;
    logic [15:0] port;
    kind  = $urandom_range(0, 99);
    count = $urandom_range(1, 4);
    idx   = 8'($urandom);
    if (kind < 8) begin
      if ($urandom_range(0, 3) != 0) idx[0] = 1'b1;
      send_item(OP_WRITE, PORT_MISC_WR, idx);
    end else if (kind < 32) begin
      if ($urandom_range(0, 3) != 0) idx[3:0] = 4'($urandom_range(SEQ_ID, SEQ_BANK));
      send_item(OP_WRITE, PORT_SEQ_IDX, idx);
      repeat (count) send_item(any_op(), PORT_SEQ_DATA, 8'($urandom));
    end else if (kind < 48) begin
      if ($urandom_range(0, 3) != 0) idx[3:0] = ($urandom_range(0, 1) != 0) ? GFX_BANK
                                                                            : GFX_BANK_CTL;
      send_item(OP_WRITE, PORT_GFX_IDX, idx);
      repeat (count) send_item(any_op(), PORT_GFX_DATA, 8'($urandom));
    end else if (kind < 76) begin
      case ($urandom_range(0, 4))
        0: idx[5:0] = 6'($urandom_range(0, CRTC_PROT_LAST));
        1: idx[5:0] = CRTC_PROT_REG;
        2: idx[5:0] = 6'($urandom_range(CRTC_FIXED_LO, CRTC_FIXED_HI));
        default: ;
      endcase
      send_item(OP_WRITE, either_block(PORT_CRTC_IDX), idx);
      repeat (count) begin
        port = either_block(($urandom_range(0, 5) == 0) ? PORT_CRTC_IDX : PORT_CRTC_DATA);
        send_item(any_op(), port, 8'($urandom));
      end
    end else if (kind < 88) begin
      port = either_block(($urandom_range(0, 1) != 0) ? PORT_ALT_WR : PORT_ALT_RD);
      send_item(any_op(), port, idx);
    end else if (kind < 94) begin
      port = ($urandom_range(0, 4) == 0) ? PORT_BANK_PASS
                                         : 16'($urandom_range(DAC_FIRST, DAC_LAST));
      send_item(any_op(), port, idx);
    end else begin
      send_item(any_op(), 16'($urandom), idx);
    end
  endtask

  initial begin : stimulus
    int unsigned random_end;
    bit          hold_done;
    bit          drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_WRITE, PORT_MISC_WR, 8'h01);
    send_item(OP_WRITE, PORT_SEQ_IDX, {4'h0, SEQ_ID});
    send_item(OP_READ,  PORT_SEQ_DATA, 8'hFF);
    send_item(OP_WRITE, PORT_SEQ_DATA, 8'h00);
    send_item(OP_WRITE, PORT_SEQ_IDX, {4'h0, SEQ_CTRL_TWO});
    send_item(OP_WRITE, PORT_SEQ_DATA, 8'hFF);
    send_item(OP_WRITE, PORT_SEQ_IDX, {4'hF, SEQ_POWER_UP});
    send_item(OP_WRITE, PORT_SEQ_DATA, 8'hA5);
    send_item(OP_WRITE, PORT_SEQ_IDX, {4'h0, SEQ_BANK});
    send_item(OP_WRITE, PORT_SEQ_DATA, 8'hFF);
    send_item(OP_WRITE, PORT_SEQ_IDX, {4'h0, SEQ_POWER_UP});
    send_item(OP_WRITE, PORT_SEQ_DATA, 8'h5A);
    send_item(OP_READ,  PORT_SEQ_DATA, 8'h00);
    send_item(OP_WRITE, PORT_GFX_IDX, {4'h0, GFX_BANK_CTL});
    send_item(OP_WRITE, PORT_GFX_DATA, 8'h05);
    send_item(OP_WRITE, PORT_GFX_IDX, {4'h0, GFX_BANK});
    send_item(OP_WRITE, PORT_GFX_DATA, 8'h00);
    send_item(OP_WRITE, PORT_ALT_WR, 8'hFF);
    send_item(OP_WRITE, PORT_ALT_RD, 8'h1F);
    send_item(OP_WRITE, PORT_CRTC_IDX, {2'b00, CRTC_PROT_REG});
    send_item(OP_WRITE, PORT_CRTC_DATA, 8'h80);
    send_item(OP_WRITE, PORT_CRTC_IDX, 8'h00);
    send_item(OP_WRITE, PORT_CRTC_DATA, 8'hFF);
    send_item(OP_WRITE, PORT_CRTC_IDX, 8'hFF);
    send_item(OP_WRITE, PORT_CRTC_DATA, 8'hFF);
    send_item(OP_WRITE, PORT_CRTC_IDX, {2'b00, CRTC_FIXED_LO});
    send_item(OP_WRITE, PORT_CRTC_DATA, 8'h5A);
    send_item(OP_WRITE, PORT_MISC_WR, 8'h00);
    send_item(OP_READ,  {PORT_MONO_BLK, PORT_ALT_RD[3:0]}, 8'h00);
    send_item(OP_READ,  PORT_CRTC_DATA, 8'h00);
    send_item(OP_READ,  DAC_WR_INDEX, 8'h00);
    send_item(OP_WRITE, 16'hFFFF, 8'hFF);
    wait_for_results();

    random_end = items_sent + RANDOM_ITEMS;
    while (items_sent < random_end) begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && items_sent >= DRAIN_AT) begin
        wait_for_results();
        drain_done = 1'b1;
      end
      random_sequence();
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0) $display("PASS svga_extended_register_port");
    else $display("FAIL svga_extended_register_port");
    $finish;
  end

endmodule
